// ===== src/escape_time_fractal_iteration_defines.svh =====
// assertion macros shared by the escape-time fractal design
// the clock and reset names of the asserting module are used directly
`ifndef ESCAPE_TIME_FRACTAL_ITERATION_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATION_DEFINES_SVH

// same-cycle implication
`define ETF_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/etf_pkg.sv =====
// types, constants and helpers for the escape-time fractal engine
// no dependencies
`default_nettype none

package etf_pkg;

   typedef logic signed [31:0] etf_fix_type;
   typedef logic [15:0]        etf_count_type;

   typedef struct packed {
      logic [11:0] pixel_row;
      logic [11:0] pixel_col;
   } etf_req_type;

   typedef struct packed {
      logic [7:0] color_index;
   } etf_rsp_type;

   // word travelling around the ring of cells
   typedef struct packed {
      logic          tok;
      logic          run;
      etf_count_type count;
      etf_fix_type   zre;
      etf_fix_type   zim;
   } etf_word_type;

   typedef enum logic [2:0] {
      REG_MODE_SELECT      = 3'd0,
      REG_ORIGIN_REAL      = 3'd1,
      REG_ORIGIN_IMAG      = 3'd2,
      REG_PIXEL_STEP       = 3'd3,
      REG_ITERATION_LIMIT  = 3'd4,
      REG_JULIA_CONST_REAL = 3'd5,
      REG_JULIA_CONST_IMAG = 3'd6
   } etf_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_RUN
   } etf_state_type;

   // 4.0 in Q8.56
   localparam logic [63:0] ESCAPE_MAG = 64'h0400_0000_0000_0000;

   localparam logic signed [63:0] SAT_HI  = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO  = 64'shFFFF_FFFF_8000_0000;
   localparam etf_fix_type        FIX_MAX = 32'sh7FFF_FFFF;
   localparam etf_fix_type        FIX_MIN = 32'sh8000_0000;

   function automatic etf_fix_type sat32(input logic signed [63:0] value);
      etf_fix_type result;
      if (value > SAT_HI) begin
         result = FIX_MAX;
      end else if (value < SAT_LO) begin
         result = FIX_MIN;
      end else begin
         result = value[31:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== src/etf_stream_if.sv =====
// valid/ready stream carrying one word per handshake
// payload type is a parameter, set to etf_pkg types by its users
`default_nettype none

interface etf_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/etf_coord.sv =====
// pixel index to complex point mapping, two register stages
// uses etf_pkg
`default_nettype none

module etf_coord (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [11:0]          row,
   input  wire logic [11:0]          col,
   input  wire etf_pkg::etf_fix_type origin_re,
   input  wire etf_pkg::etf_fix_type origin_im,
   input  wire logic [30:0]          step,
   output logic                      done,
   output etf_pkg::etf_fix_type      point_re,
   output etf_pkg::etf_fix_type      point_im
);

   logic                 prod_vld_ff, prod_vld_in;
   logic [42:0]          prod_re_ff, prod_re_in;
   logic [42:0]          prod_im_ff, prod_im_in;
   logic                 point_vld_ff, point_vld_in;
   etf_pkg::etf_fix_type point_re_ff, point_re_in;
   etf_pkg::etf_fix_type point_im_ff, point_im_in;
   logic signed [44:0]   sum_re;
   logic signed [44:0]   sum_im;

   assign prod_vld_in = start;
   assign prod_re_in  = 43'(col) * 43'(step);
   assign prod_im_in  = 43'(row) * 43'(step);

   assign sum_re = $signed({2'b00, prod_re_ff}) + 45'(origin_re);
   assign sum_im = $signed({2'b00, prod_im_ff}) + 45'(origin_im);

   assign point_vld_in = prod_vld_ff;
   assign point_re_in  = etf_pkg::sat32(64'(sum_re));
   assign point_im_in  = etf_pkg::sat32(64'(sum_im));

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         point_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff  <= prod_vld_in;
         point_vld_ff <= point_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff  <= prod_re_in;
      prod_im_ff  <= prod_im_in;
      point_re_ff <= point_re_in;
      point_im_ff <= point_im_in;
   end

   assign done     = point_vld_ff;
   assign point_re = point_re_ff;
   assign point_im = point_im_ff;

endmodule

`default_nettype wire

// ===== src/etf_cell.sv =====
// one iteration cell: multiply stage then escape test and z*z + c update
// uses etf_pkg and the assertion macros
`default_nettype none
`include "escape_time_fractal_iteration_defines.svh"

module etf_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire etf_pkg::etf_word_type in_word,
   input  wire etf_pkg::etf_fix_type  c_re,
   input  wire etf_pkg::etf_fix_type  c_im,
   input  wire etf_pkg::etf_count_type limit,
   output etf_pkg::etf_word_type      out_word
);

   etf_pkg::etf_word_type s1_ff, s1_in;
   logic signed [63:0]    rr_ff, rr_in;
   logic signed [63:0]    ii_ff, ii_in;
   logic signed [63:0]    ri_ff, ri_in;
   etf_pkg::etf_word_type s2_ff, s2_in;
   logic [63:0]           mag;
   logic signed [63:0]    diff;
   logic                  keep_going;
   etf_pkg::etf_fix_type  next_re;
   etf_pkg::etf_fix_type  next_im;

   // stage 1: products of the current z
   assign s1_in = in_word;
   assign rr_in = $signed(in_word.zre) * $signed(in_word.zre);
   assign ii_in = $signed(in_word.zim) * $signed(in_word.zim);
   assign ri_in = $signed(in_word.zre) * $signed(in_word.zim);

   // stage 2: escape test and update
   assign mag        = 64'(rr_ff + ii_ff);
   assign diff       = rr_ff - ii_ff;
   assign keep_going = s1_ff.run && (s1_ff.count < limit) && (mag < etf_pkg::ESCAPE_MAG);
   assign next_re    = etf_pkg::sat32((diff >>> 28) + 64'(c_re));
   assign next_im    = etf_pkg::sat32((ri_ff >>> 27) + 64'(c_im));

   always_comb begin
      s2_in     = s1_ff;
      s2_in.run = keep_going;
      if (keep_going) begin
         s2_in.count = s1_ff.count + 16'd1;
         s2_in.zre   = next_re;
         s2_in.zim   = next_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.tok <= 1'b0;
         s2_ff.tok <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff <= rr_in;
      ii_ff <= ii_in;
      ri_ff <= ri_in;
   end

   assign out_word = s2_ff;

   `ETF_ASSERT_IMPLIES(a_single_token, s1_ff.tok, !s2_ff.tok, "two words in one cell")
   `ETF_ASSERT_IMPLIES(a_run_counted, s2_ff.tok && s2_ff.run, s2_ff.count != 16'd0, "running word without an iteration")
   `ETF_ASSERT_IMPLIES(a_count_bound, s2_ff.tok, s2_ff.count <= limit, "count beyond iteration limit")

endmodule

`default_nettype wire

// ===== src/escape_time_fractal_iteration.sv =====
// top level of the escape-time fractal engine: registers, sequencer, ring of cells
// uses etf_pkg, etf_stream_if, etf_coord, etf_cell and the assertion macros

// One pixel is worked on at a time. After a word is taken on req_chan the row and
// column are mapped to a complex point in the two register stages of etf_coord, then
// the pixel's state goes round a ring of NUM_CELLS iteration cells, each a 2-stage
// multiply/update pipeline that does one z*z + c step, and the next pixel is taken the
// cycle after the result is loaded into the output register. Mandelbrot mode starts
// from z = 0 with c at the point; Julia mode starts from z at the point with c from
// the julia constant registers. Result is the count mod 256.
`default_nettype none
`include "escape_time_fractal_iteration_defines.svh"

module escape_time_fractal_iteration #(
   parameter int NUM_CELLS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   etf_stream_if.sink       req_chan,
   etf_stream_if.source     rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic                   mode_ff;
   etf_pkg::etf_fix_type   origin_re_ff;
   etf_pkg::etf_fix_type   origin_im_ff;
   logic [30:0]            step_ff;
   etf_pkg::etf_count_type limit_ff;
   etf_pkg::etf_fix_type   julia_re_ff;
   etf_pkg::etf_fix_type   julia_im_ff;

   etf_pkg::etf_state_type state_ff, state_in;
   logic                   req_ready;
   logic                   coord_start;
   logic                   coord_done;
   etf_pkg::etf_fix_type   point_re;
   etf_pkg::etf_fix_type   point_im;
   etf_pkg::etf_fix_type   c_re_ff, c_re_in;
   etf_pkg::etf_fix_type   c_im_ff, c_im_in;
   etf_pkg::etf_word_type  init_word;
   etf_pkg::etf_word_type  chain_in;
   etf_pkg::etf_word_type  ring_out;
   etf_pkg::etf_word_type  link [NUM_CELLS+1];
   logic                   slot_free;
   logic                   capture;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_color_ff, rsp_color_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         origin_re_ff <= -32'sd536870912;
         origin_im_ff <= -32'sd536870912;
         step_ff      <= 31'd1048576;
         limit_ff     <= 16'd256;
         julia_re_ff  <= '0;
         julia_im_ff  <= '0;
      end else if (csr_wr_en) begin
         case (etf_pkg::etf_reg_type'(csr_index))
            etf_pkg::REG_MODE_SELECT:      mode_ff      <= csr_wdata[0];
            etf_pkg::REG_ORIGIN_REAL:      origin_re_ff <= csr_wdata;
            etf_pkg::REG_ORIGIN_IMAG:      origin_im_ff <= csr_wdata;
            etf_pkg::REG_PIXEL_STEP:       step_ff      <= csr_wdata[30:0];
            etf_pkg::REG_ITERATION_LIMIT:  limit_ff     <= csr_wdata[15:0];
            etf_pkg::REG_JULIA_CONST_REAL: julia_re_ff  <= csr_wdata;
            etf_pkg::REG_JULIA_CONST_IMAG: julia_im_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   etf_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .start     (coord_start),
      .row       (req_chan.data.pixel_row),
      .col       (req_chan.data.pixel_col),
      .origin_re (origin_re_ff),
      .origin_im (origin_im_ff),
      .step      (step_ff),
      .done      (coord_done),
      .point_re  (point_re),
      .point_im  (point_im)
   );

   // ring of cells
   assign link[0]  = chain_in;
   assign ring_out = link[NUM_CELLS];

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      etf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_word  (link[k]),
         .c_re     (c_re_ff),
         .c_im     (c_im_ff),
         .limit    (limit_ff),
         .out_word (link[k+1])
      );
   end

   always_comb begin
      init_word       = '0;
      init_word.tok   = 1'b1;
      init_word.run   = 1'b1;
      init_word.count = '0;
      init_word.zre   = mode_ff ? point_re : '0;
      init_word.zim   = mode_ff ? point_im : '0;
   end

   assign c_re_in   = mode_ff ? julia_re_ff : point_re;
   assign c_im_in   = mode_ff ? julia_im_ff : point_im;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      coord_start = 1'b0;
      chain_in    = '0;
      capture     = 1'b0;
      case (state_ff)
         etf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               coord_start = 1'b1;
               state_in    = etf_pkg::ST_MAP;
            end
         end
         etf_pkg::ST_MAP: begin
            if (coord_done) begin
               chain_in = init_word;
               state_in = etf_pkg::ST_RUN;
            end
         end
         etf_pkg::ST_RUN: begin
            if (ring_out.tok) begin
               // finished word waits in the ring while the output is full
               if (ring_out.run || !slot_free) begin
                  chain_in = ring_out;
               end else begin
                  capture  = 1'b1;
                  state_in = etf_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = etf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == etf_pkg::ST_MAP && coord_done) begin
         c_re_ff <= c_re_in;
         c_im_ff <= c_im_in;
      end
   end

   // output register
   assign rsp_valid_in = capture || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_color_in = capture ? ring_out.count[7:0] : rsp_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff <= rsp_color_in;
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.data.color_index = rsp_color_ff;

   `ETF_ASSERT_IMPLIES(a_idle_ring_empty, state_ff == etf_pkg::ST_IDLE, !ring_out.tok, "word in ring while idle")
   `ETF_ASSERT_NEXT(a_accept_maps, req_chan.valid && req_chan.ready, state_ff == etf_pkg::ST_MAP, "accept did not start mapping")
   `ETF_ASSERT_IMPLIES(a_rsp_from_ring, $rose(rsp_valid_ff), $past(ring_out.tok && !ring_out.run), "result without finished word")

endmodule

`default_nettype wire

// ===== sim/escape_time_fractal_iteration_tb.sv =====
// self-checking testbench for escape_time_fractal_iteration: directed table, then random phases
// depends on etf_pkg, etf_stream_if and the escape_time_fractal_iteration rtl
module escape_time_fractal_iteration_tb;

   localparam logic [2:0]        REG_UNUSED   = 3'd7;
   localparam int                RANDOM_ITEMS = 935;
   localparam int                CYCLE_LIMIT  = 4000000;
   localparam int                TAIL_CYCLES  = 64;
   localparam int                PLAN_ROWS    = 34;
   localparam logic signed [63:0] WIDE_MAX    = 64'sd2147483647;
   localparam logic signed [63:0] WIDE_MIN    = -64'sd2147483648;

   typedef struct packed {
      bit          is_write;
      logic [2:0]  index;
      logic [31:0] wdata;
      logic [11:0] row;
      logic [11:0] col;
      bit          typed;
      logic [7:0]  color;
   } plan_row_type;

   typedef struct packed {
      logic [11:0] row;
      logic [11:0] col;
      logic [7:0]  color;
   } pending_color_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   etf_stream_if #(.payload_type(etf_pkg::etf_req_type)) req_if ();
   etf_stream_if #(.payload_type(etf_pkg::etf_rsp_type)) rsp_if ();

   escape_time_fractal_iteration DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the register file
   logic                 cfg_mode;
   etf_pkg::etf_fix_type cfg_origin_re;
   etf_pkg::etf_fix_type cfg_origin_im;
   logic [30:0]          cfg_step;
   logic [15:0]          cfg_limit;
   etf_pkg::etf_fix_type cfg_julia_re;
   etf_pkg::etf_fix_type cfg_julia_im;

   pending_color_type pending_colors[$];
   pending_color_type head;
   plan_row_type      directed_plan [PLAN_ROWS];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                idle_pct = 6;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic plan_row_type wr(input logic [2:0] idx, input logic [31:0] data);
      plan_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.index = idx;
      r.wdata = data;
      return r;
   endfunction

   function automatic plan_row_type px(input logic [11:0] row, input logic [11:0] col);
      plan_row_type r;
      r = '0;
      r.row = row;
      r.col = col;
      return r;
   endfunction

   function automatic plan_row_type pxk(input logic [11:0] row, input logic [11:0] col,
                                        input logic [7:0] color);
      plan_row_type r;
      r = px(row, col);
      r.typed = 1'b1;
      r.color = color;
      return r;
   endfunction

   function automatic etf_pkg::etf_fix_type clamp_fix(input logic signed [63:0] v);
      if (v > WIDE_MAX) return etf_pkg::FIX_MAX;
      if (v < WIDE_MIN) return etf_pkg::FIX_MIN;
      return v[31:0];
   endfunction

   function automatic logic [63:0] norm_sq(input etf_pkg::etf_fix_type re,
                                           input etf_pkg::etf_fix_type im);
      logic signed [63:0] a;
      logic signed [63:0] b;
      a = re;
      b = im;
      return a * a + b * b;
   endfunction

   function automatic void store_reg(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         etf_pkg::REG_MODE_SELECT:      cfg_mode = data[0];
         etf_pkg::REG_ORIGIN_REAL:      cfg_origin_re = data;
         etf_pkg::REG_ORIGIN_IMAG:      cfg_origin_im = data;
         etf_pkg::REG_PIXEL_STEP:       cfg_step = data[30:0];
         etf_pkg::REG_ITERATION_LIMIT:  cfg_limit = data[15:0];
         etf_pkg::REG_JULIA_CONST_REAL: cfg_julia_re = data;
         etf_pkg::REG_JULIA_CONST_IMAG: cfg_julia_im = data;
         default: ;
      endcase
   endfunction

   // escape-time count of one pixel under the current register values
   function automatic logic [7:0] escape_color(input logic [11:0] row, input logic [11:0] col);
      logic [63:0]          offset_re;
      logic [63:0]          offset_im;
      logic signed [63:0]   wide_re;
      logic signed [63:0]   wide_im;
      logic signed [63:0]   zr;
      logic signed [63:0]   zi;
      logic signed [63:0]   rr;
      logic signed [63:0]   ii;
      logic signed [63:0]   ri;
      logic signed [63:0]   nre;
      logic signed [63:0]   nim;
      etf_pkg::etf_fix_type pt_re;
      etf_pkg::etf_fix_type pt_im;
      etf_pkg::etf_fix_type z_re;
      etf_pkg::etf_fix_type z_im;
      etf_pkg::etf_fix_type c_re;
      etf_pkg::etf_fix_type c_im;
      int unsigned          steps;
      offset_re = 64'(col) * 64'(cfg_step);
      offset_im = 64'(row) * 64'(cfg_step);
      wide_re = {{32{cfg_origin_re[31]}}, cfg_origin_re} + offset_re;
      wide_im = {{32{cfg_origin_im[31]}}, cfg_origin_im} + offset_im;
      pt_re = clamp_fix(wide_re);
      pt_im = clamp_fix(wide_im);
      if (cfg_mode) begin
         z_re = pt_re;
         z_im = pt_im;
         c_re = cfg_julia_re;
         c_im = cfg_julia_im;
      end else begin
         z_re = '0;
         z_im = '0;
         c_re = pt_re;
         c_im = pt_im;
      end
      steps = 0;
      while (steps < cfg_limit && norm_sq(z_re, z_im) < etf_pkg::ESCAPE_MAG) begin
         zr = z_re;
         zi = z_im;
         rr = zr * zr;
         ii = zi * zi;
         ri = zr * zi;
         nre = ((rr - ii) >>> 28) + c_re;
         nim = (ri >>> 27) + c_im;
         z_re = clamp_fix(nre);
         z_im = clamp_fix(nim);
         steps++;
      end
      return steps[7:0];
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      store_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [11:0] row, input logic [11:0] col,
                             input bit typed, input logic [7:0] color);
      pending_color_type entry;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= '{pixel_row: row, pixel_col: col};
      do @(posedge clock); while (!req_if.ready);
      entry.row = row;
      entry.col = col;
      entry.color = typed ? color : escape_color(row, col);
      pending_colors.push_back(entry);
   endtask

   task automatic wait_idle();
      if (req_if.valid) req_if.valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
   endtask

   // result checking and sink back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_colors.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual color_index %0d",
                     $time, rsp_if.data.color_index);
            mismatch_count++;
         end else begin
            head = pending_colors.pop_front();
            if (rsp_if.data.color_index !== head.color) begin
               $display("%0t: color_index mismatch at row %0d col %0d: expected %0d, actual %0d",
                        $time, head.row, head.col, head.color, rsp_if.data.color_index);
               mismatch_count++;
            end
         end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int          sent;
      int          phase;
      int          kind;
      int          burst;
      int          o_re;
      int          o_im;
      int          j_re;
      int          j_im;
      logic [31:0] step;
      logic [31:0] lim;
      logic [11:0] row;
      logic [11:0] col;

      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = etf_pkg::REG_MODE_SELECT;
      csr_wdata = '0;

      cfg_mode = 1'b0;
      cfg_origin_re = -536870912;
      cfg_origin_im = -536870912;
      cfg_step = 31'd1048576;
      cfg_limit = 16'd256;
      cfg_julia_re = '0;
      cfg_julia_im = '0;

      directed_plan = '{
         px(12'd0, 12'd0),
         px(12'd4095, 12'd4095),
         px(12'd128, 12'd128),
         wr(REG_UNUSED, 32'hFFFF_FFFF),
         px(12'd128, 12'd128),
         wr(etf_pkg::REG_ITERATION_LIMIT, 32'd0),
         pxk(12'd0, 12'd0, 8'd0),
         pxk(12'd4095, 12'd4095, 8'd0),
         wr(etf_pkg::REG_ITERATION_LIMIT, 32'hFFFF_0001),
         px(12'd2048, 12'd1),
         wr(etf_pkg::REG_MODE_SELECT, 32'hFFFF_FFFF),
         wr(etf_pkg::REG_ITERATION_LIMIT, 32'd256),
         wr(etf_pkg::REG_ORIGIN_REAL, etf_pkg::FIX_MIN),
         wr(etf_pkg::REG_ORIGIN_IMAG, etf_pkg::FIX_MAX),
         pxk(12'd0, 12'd0, 8'd0),
         wr(etf_pkg::REG_ORIGIN_REAL, etf_pkg::FIX_MAX),
         wr(etf_pkg::REG_PIXEL_STEP, 32'hFFFF_FFFF),
         pxk(12'd4095, 12'd4095, 8'd0),
         wr(etf_pkg::REG_ORIGIN_REAL, 32'hE800_0000),
         wr(etf_pkg::REG_ORIGIN_IMAG, 32'hF000_0000),
         wr(etf_pkg::REG_PIXEL_STEP, 32'h0006_0000),
         wr(etf_pkg::REG_JULIA_CONST_REAL, -214748365),
         wr(etf_pkg::REG_JULIA_CONST_IMAG, 41875931),
         px(12'd341, 12'd512),
         px(12'd600, 12'd300),
         wr(etf_pkg::REG_JULIA_CONST_REAL, etf_pkg::FIX_MIN),
         wr(etf_pkg::REG_JULIA_CONST_IMAG, etf_pkg::FIX_MAX),
         px(12'd341, 12'd512),
         wr(etf_pkg::REG_MODE_SELECT, 32'd0),
         wr(etf_pkg::REG_ORIGIN_REAL, 32'd0),
         wr(etf_pkg::REG_ORIGIN_IMAG, 32'd0),
         wr(etf_pkg::REG_PIXEL_STEP, 32'd0),
         wr(etf_pkg::REG_ITERATION_LIMIT, 32'h0000_FFFF),
         pxk(12'd4095, 12'd4095, 8'd255)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write) begin
            wait_idle();
            write_reg(directed_plan[i].index, directed_plan[i].wdata);
         end else begin
            send_pixel(directed_plan[i].row, directed_plan[i].col,
                       directed_plan[i].typed, directed_plan[i].color);
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         idle_pct = (phase >= 6 && phase < 11) ? 0 : 6;
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            // windows around the interesting part of the plane
            o_re = -671088640 + int'($urandom_range(0, 805306368));
            o_im = -402653184 + int'($urandom_range(0, 805306368));
            step = $urandom_range(0, 196608);
            j_re = -268435456 + int'($urandom_range(0, 536870912));
            j_im = -268435456 + int'($urandom_range(0, 536870912));
            lim = (kind == 6) ? $urandom_range(65, 300) : $urandom_range(1, 64);
         end else begin
            o_re = $urandom();
            o_im = $urandom();
            step = $urandom();
            j_re = $urandom();
            j_im = $urandom();
            lim = (kind == 9) ? $urandom_range(0, 1) : $urandom_range(0, 300);
         end
         write_reg(etf_pkg::REG_MODE_SELECT,
                   ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1));
         write_reg(etf_pkg::REG_ORIGIN_REAL, o_re);
         write_reg(etf_pkg::REG_ORIGIN_IMAG, o_im);
         write_reg(etf_pkg::REG_PIXEL_STEP, step);
         write_reg(etf_pkg::REG_ITERATION_LIMIT, ($urandom() & 32'hFFFF_0000) | lim);
         write_reg(etf_pkg::REG_JULIA_CONST_REAL, j_re);
         write_reg(etf_pkg::REG_JULIA_CONST_IMAG, j_im);
         if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            if ($urandom_range(0, 3) == 0) begin
               row = $urandom_range(0, 63);
               col = $urandom_range(0, 63);
            end else begin
               row = $urandom_range(0, 4095);
               col = $urandom_range(0, 4095);
            end
            send_pixel(row, col, 1'b0, 8'd0);
            sent++;
         end
         phase++;
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
